FILE: rtl/core/sync_hunt_length_prefixed_deframer_assert.svh
// assertion macros for the sync hunt deframer
// no dependencies; included by sync_hunt_length_prefixed_deframer

`ifndef SYNC_HUNT_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define SYNC_HUNT_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// condition implies consequence in the same cycle
`define SHLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define SHLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/shld_pkg.sv
// shared types and constants of the sync hunt deframer
// no dependencies; imported by sync_hunt_length_prefixed_deframer

package shld_pkg;

   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_REJECT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_TX      = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   localparam logic REG_HUNT_PERIOD   = 1'b0;
   localparam logic REG_LOCKED_PERIOD = 1'b1;

   localparam int          PERIOD_W            = 14;
   localparam logic [13:0] HUNT_PERIOD_RESET   = 14'd1000;
   localparam logic [13:0] LOCKED_PERIOD_RESET = 14'd10000;

   localparam logic [63:0] SYNC_WORD   = 64'hFE06_FC0B_4CFA_FAFF;
   localparam logic [7:0]  INBAND_TYPE = 8'd254;
   localparam int          INBAND_LEN  = 6;

   // sync word bytes in transmit order
   function automatic logic [7:0] sync_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'hFE;
         3'd1:    b = 8'h06;
         3'd2:    b = 8'hFC;
         3'd3:    b = 8'h0B;
         3'd4:    b = 8'h4C;
         3'd5:    b = 8'hFA;
         3'd6:    b = 8'hFA;
         default: b = 8'hFF;
      endcase
      return b;
   endfunction

   // one result, or a whole sync burst when burst is set
   typedef struct packed {
      logic       burst;
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] type_byte;
      logic       last;
      logic       locked;
   } rsp_desc_type;

endpackage

FILE: rtl/core/sync_hunt_length_prefixed_deframer.sv
// sync hunt, length-prefixed deframer with periodic sync word transmission
// depends on shld_pkg and sync_hunt_length_prefixed_deframer_assert.svh

// Usage
//  req channel: one transaction per command; tuser carries the command
//    (received byte, time tick, consumer reject), tdata the received byte.
//  rsp channel: payload bytes, empty-message notices, sync bytes to transmit
//    and framing errors; tuser is the kind, tlast marks the last payload
//    byte, an empty-message notice or the eighth sync byte.
//  csr port: single-cycle writes of hunt_period and locked_period.
// Timing
//  one command is accepted every cycle while req_tready is high; the frame
//  state is updated on the accepting edge, the result is held in a pending
//  register and moves into the output register once that is free, to be
//  offered. A tick that fires sends eight sync bytes, holding the output
//  register until the last is taken; meanwhile commands without a result
//  keep flowing, one result waits in the pending slot and the input waits.
// Reset
//  synchronous; the block hunts, history is cleared and the first tick
//  transmits the sync word. Periods return to 1000 and 10000 ticks.
//  req_tready stays low while reset is high.
// Stalls
//  a stalled receiver holds the output register; the pending register
//  absorbs one further result before req_tready drops.

module sync_hunt_length_prefixed_deframer
   import shld_pkg::*;
#(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [15:8] out_type, [16] out_locked
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast,   // out_last
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [13:0] csr_wdata
);

   `include "sync_hunt_length_prefixed_deframer_assert.svh"

   localparam int         LEN_W   = $clog2(MAX_PAYLOAD);
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD - 1);

   typedef enum logic [1:0] {
      STG_TYPE    = 2'd0,
      STG_LENGTH  = 2'd1,
      STG_PAYLOAD = 2'd2
   } stage_type;

   // frame state
   logic                hunting_ff, hunting_in;
   logic [63:0]         rx_history_ff, rx_history_in;
   stage_type           frame_stage_ff, frame_stage_in;
   logic [7:0]          frame_type_ff, frame_type_in;
   logic [LEN_W-1:0]    frame_length_ff, frame_length_in;
   logic [LEN_W-1:0]    payload_index_ff, payload_index_in;
   logic                inband_match_ff, inband_match_in;
   logic [PERIOD_W-1:0] send_countdown_ff, send_countdown_in;
   logic [PERIOD_W-1:0] hunt_period_ff, locked_period_ff;

   // pending slot and output register
   logic         pend_valid_ff;
   rsp_desc_type pend_desc_ff;
   logic         out_valid_ff;
   rsp_desc_type out_desc_ff;
   logic [2:0]   burst_idx_ff;

   logic          accept;
   logic          res_valid;
   rsp_desc_type  res_desc;
   logic          go_hunt;
   logic          out_final;
   logic          out_free;
   logic          pend_move;
   logic [LEN_W:0] index_next;
   logic          last_byte;
   logic          is_inband;
   logic [PERIOD_W-1:0] period_sel;
   logic [7:0]    rx_byte;

   assign rx_byte   = req_tdata;
   assign out_final = !out_desc_ff.burst || (burst_idx_ff == 3'd7);
   assign out_free  = !out_valid_ff || (rsp_tready && out_final);
   assign pend_move = pend_valid_ff && out_free;
   assign req_tready = !reset && (!pend_valid_ff || out_free);
   assign accept    = req_tvalid && req_tready;

   assign index_next = {1'b0, payload_index_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign last_byte  = index_next >= {1'b0, frame_length_ff};
   assign is_inband  = frame_type_ff == INBAND_TYPE;
   assign period_sel = hunting_ff ? hunt_period_ff : locked_period_ff;

   always_comb begin
      hunting_in         = hunting_ff;
      rx_history_in      = rx_history_ff;
      frame_stage_in     = frame_stage_ff;
      frame_type_in      = frame_type_ff;
      frame_length_in    = frame_length_ff;
      payload_index_in   = payload_index_ff;
      inband_match_in    = inband_match_ff;
      send_countdown_in  = send_countdown_ff;
      go_hunt            = 1'b0;
      res_valid          = 1'b0;
      res_desc           = '0;
      res_desc.type_byte = frame_type_ff;

      if (accept) begin
         case (cmd_type'(req_tuser))
            CMD_BYTE: begin
               if (hunting_ff) begin
                  rx_history_in = {rx_history_ff[55:0], rx_byte};
                  if (rx_history_in == SYNC_WORD) begin
                     // lock; countdown kept, locked period from next reload
                     hunting_in       = 1'b0;
                     frame_stage_in   = STG_TYPE;
                     payload_index_in = '0;
                     inband_match_in  = 1'b1;
                  end
               end else begin
                  case (frame_stage_ff)
                     STG_TYPE: begin
                        frame_type_in  = rx_byte;
                        frame_stage_in = STG_LENGTH;
                     end
                     STG_LENGTH: begin
                        if (rx_byte > MAX_LEN) begin
                           res_valid     = 1'b1;
                           res_desc.kind = KIND_ERROR;
                           go_hunt       = 1'b1;
                        end else begin
                           frame_length_in  = rx_byte[LEN_W-1:0];
                           payload_index_in = '0;
                           inband_match_in  = !is_inband ||
                                              (frame_length_in == LEN_W'(INBAND_LEN));
                           if (frame_length_in == '0) begin
                              frame_stage_in = STG_TYPE;
                              res_valid      = 1'b1;
                              if (is_inband) begin
                                 res_desc.kind = KIND_ERROR;
                                 go_hunt       = 1'b1;
                              end else begin
                                 res_desc.kind = KIND_EMPTY;
                                 res_desc.last = 1'b1;
                              end
                           end else begin
                              frame_stage_in = STG_PAYLOAD;
                           end
                        end
                     end
                     default: begin
                        // payload byte
                        if (is_inband) begin
                           if ((payload_index_ff >= LEN_W'(INBAND_LEN)) ||
                               (rx_byte != sync_byte(payload_index_ff[2:0] + 3'd2)))
                              inband_match_in = 1'b0;
                        end else begin
                           res_valid     = 1'b1;
                           res_desc.kind = KIND_PAYLOAD;
                           res_desc.data = rx_byte;
                           res_desc.last = last_byte;
                        end
                        payload_index_in = index_next[LEN_W-1:0];
                        if (last_byte) begin
                           frame_stage_in   = STG_TYPE;
                           payload_index_in = '0;
                           if (is_inband && !inband_match_in) begin
                              res_valid     = 1'b1;
                              res_desc.kind = KIND_ERROR;
                              go_hunt       = 1'b1;
                           end
                        end
                     end
                  endcase
               end
            end
            CMD_TICK: begin
               if (send_countdown_ff == '0) begin
                  res_valid          = 1'b1;
                  res_desc.burst     = 1'b1;
                  res_desc.kind      = KIND_TX;
                  res_desc.type_byte = '0;
                  // a zero period behaves as one
                  send_countdown_in = (period_sel == '0) ? '0 : period_sel - 1'b1;
               end else begin
                  send_countdown_in = send_countdown_ff - 1'b1;
               end
            end
            CMD_REJECT: begin
               if (!hunting_ff) begin
                  res_valid     = 1'b1;
                  res_desc.kind = KIND_ERROR;
                  go_hunt       = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (go_hunt) begin
         hunting_in       = 1'b1;
         rx_history_in    = '0;
         frame_stage_in   = STG_TYPE;
         payload_index_in = '0;
         inband_match_in  = 1'b1;
      end

      res_desc.locked = !hunting_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff        <= 1'b1;
         rx_history_ff     <= '0;
         frame_stage_ff    <= STG_TYPE;
         frame_type_ff     <= '0;
         frame_length_ff   <= '0;
         payload_index_ff  <= '0;
         inband_match_ff   <= 1'b1;
         send_countdown_ff <= '0;
         hunt_period_ff    <= HUNT_PERIOD_RESET;
         locked_period_ff  <= LOCKED_PERIOD_RESET;
         pend_valid_ff     <= 1'b0;
         out_valid_ff      <= 1'b0;
         burst_idx_ff      <= '0;
      end else begin
         hunting_ff        <= hunting_in;
         rx_history_ff     <= rx_history_in;
         frame_stage_ff    <= frame_stage_in;
         frame_type_ff     <= frame_type_in;
         frame_length_ff   <= frame_length_in;
         payload_index_ff  <= payload_index_in;
         inband_match_ff   <= inband_match_in;
         send_countdown_ff <= send_countdown_in;

         if (csr_we) begin
            case (csr_index)
               REG_HUNT_PERIOD:   hunt_period_ff   <= csr_wdata;
               REG_LOCKED_PERIOD: locked_period_ff <= csr_wdata;
               default: ;
            endcase
         end

         // pending slot
         if (accept && res_valid) begin
            pend_valid_ff <= 1'b1;
            pend_desc_ff  <= res_desc;
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end

         // output register and sync burst counter
         if (pend_move) begin
            out_valid_ff <= 1'b1;
            out_desc_ff  <= pend_desc_ff;
            burst_idx_ff <= '0;
         end else if (out_valid_ff && rsp_tready) begin
            if (out_final) begin
               out_valid_ff <= 1'b0;
            end else begin
               burst_idx_ff <= burst_idx_ff + 3'd1;
            end
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_desc_ff.kind;
   assign rsp_tlast  = out_desc_ff.burst ? (burst_idx_ff == 3'd7) : out_desc_ff.last;
   assign rsp_tdata  = {7'd0,
                        out_desc_ff.locked,
                        out_desc_ff.type_byte,
                        out_desc_ff.burst ? sync_byte(burst_idx_ff) : out_desc_ff.data};

   // a sync burst keeps going until its eighth byte
   `SHLD_ASSERT_NEXT(a_burst_continues, clock, reset,
      out_valid_ff && out_desc_ff.burst && (burst_idx_ff != 3'd7) && rsp_tready,
      rsp_tvalid && (rsp_tuser == KIND_TX),
      "sync burst cut short")

   // an error always leaves the block hunting
   `SHLD_ASSERT_NOW(a_error_unlocked, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_ERROR),
      !rsp_tdata[16] && !rsp_tlast,
      "framing error reported as locked or last")

   // empty notices come only while locked
   `SHLD_ASSERT_NOW(a_empty_locked, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_EMPTY),
      rsp_tdata[16] && rsp_tlast,
      "empty notice without lock or last")

   // a pending result is never dropped while the output is busy
   `SHLD_ASSERT_NEXT(a_pending_held, clock, reset,
      pend_valid_ff && !out_free,
      pend_valid_ff,
      "pending result lost")

endmodule
